// ===== rtl/mpa_pkg.sv =====
// Shared types and constants of the 1D max pooling block with argmax.
// Used by every module under rtl; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package mpa_pkg;

	// configuration register file
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 11;
	localparam int CH_REG_W   = 7;
	localparam int KERN_REG_W = 7;
	localparam int ROW_REG_W  = 11;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_CHANNEL_COUNT = 2'd0,
		CFG_KERNEL_SIZE   = 2'd1,
		CFG_ROW_COUNT     = 2'd2
	} cfg_idx_t;

	localparam logic [CH_REG_W-1:0]   CH_RESET   = 7'd1;
	localparam logic [KERN_REG_W-1:0] KERN_RESET = 7'd2;
	localparam logic [ROW_REG_W-1:0]  ROW_RESET  = 11'd2;

	// window geometry
	localparam int KERNEL_MAX = 64;
	localparam int RIW_W      = 6;
	localparam int INDEX_W    = 16;

	// default parameter values
	localparam int DEF_MAX_CHANNELS = 64;
	localparam int DEF_MAX_ROWS     = 1024;
	localparam int DEF_SAMPLE_BITS  = 16;

	// decoupling queue
	localparam int QUEUE_DEPTH = 4;

	// classification of one word, handed from front to back
	typedef struct packed {
		logic first;      // first row of its window: restart the running maximum
		logic window_end; // last row of its window: emit a result
		logic frame_last; // last sample of the frame
	} pool_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/max_pool_1d_argmax_top.sv =====
// 1D max pooling with argmax: throughput one input word per clock while m_axis keeps up.
// The running-maximum memory is read and written once a cycle.
// A window-closing word passes the queue entry, the stage-1 registers and the output register
// before it shows on m_axis, and waits there while m_axis stalls.
// Reset (arst_n low, asynchronous): counters and queue empty, registers 1 / 2 / 2.
// The maximum memory has no reset; each window overwrites an entry with its first row.
`timescale 1ns / 1ps
`default_nettype none

module max_pool_1d_argmax_top
	import mpa_pkg::*;
#(
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
	parameter int MAX_ROWS     = DEF_MAX_ROWS,
	parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
	localparam int CH_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
	localparam int RW_W        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
	localparam int IN_W        = ((SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_BITS    = SAMPLE_BITS + INDEX_W + CH_W + RW_W,
	localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration write port
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	// input stream
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_W-1:0]       s_axis_tdata,  // sample
	// result stream
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_W-1:0]           m_axis_tdata,  // max_value, max_index, channel_id, window_id
	output logic                       m_axis_tlast   // frame_last
);

	localparam int Q_W = $bits(pool_ctl_t) + SAMPLE_BITS + CH_W + RW_W + INDEX_W;

	// front to queue
	logic                   push_valid, push_ready;
	pool_ctl_t              push_ctl;
	logic [SAMPLE_BITS-1:0] push_sample;
	logic [CH_W-1:0]        push_ch;
	logic [RW_W-1:0]        push_win;
	logic [INDEX_W-1:0]     push_flat;

	// queue to back
	logic                   pop_valid, pop_ready;
	logic [Q_W-1:0]         pop_data;
	pool_ctl_t              pop_ctl;
	logic [SAMPLE_BITS-1:0] pop_sample;
	logic [CH_W-1:0]        pop_ch;
	logic [RW_W-1:0]        pop_win;
	logic [INDEX_W-1:0]     pop_flat;

	// back to ports
	logic [SAMPLE_BITS-1:0] out_value;
	logic [INDEX_W-1:0]     out_index;
	logic [CH_W-1:0]        out_ch;
	logic [RW_W-1:0]        out_win;

	// Front: keep the registers and position counters, tag every word with its
	// channel, window, flat index and window/frame flags.
	mpa_front #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.MAX_ROWS     (MAX_ROWS),
		.SAMPLE_BITS  (SAMPLE_BITS),
		.CH_W         (CH_W),
		.RW_W         (RW_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_sample   (s_axis_tdata[SAMPLE_BITS-1:0]),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_ctl    (push_ctl),
		.push_sample (push_sample),
		.push_ch     (push_ch),
		.push_win    (push_win),
		.push_flat   (push_flat)
	);

	// Queue: hold tagged words while the result side stalls, so the front keeps
	// taking input until it fills.
	mpa_queue #(
		.WIDTH (Q_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_ctl, push_sample, push_ch, push_win, push_flat}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	assign {pop_ctl, pop_sample, pop_ch, pop_win, pop_flat} = pop_data;

	// Back: read the channel's running maximum, compare, write it back and
	// drive the result register. A write to the same channel in the cycle of the
	// read is forwarded, so one channel may repeat every cycle.
	mpa_back #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.SAMPLE_BITS  (SAMPLE_BITS),
		.CH_W         (CH_W),
		.RW_W         (RW_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_ctl    (pop_ctl),
		.pop_sample (pop_sample),
		.pop_ch     (pop_ch),
		.pop_win    (pop_win),
		.pop_flat   (pop_flat),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_value  (out_value),
		.out_index  (out_index),
		.out_ch     (out_ch),
		.out_win    (out_win),
		.out_last   (m_axis_tlast)
	);

	// pack the result word, first field lowest, zero fill to whole bytes
	assign m_axis_tdata = OUT_W'({out_win, out_ch, out_index, out_value});

endmodule

`default_nettype wire

// ===== rtl/mpa_front.sv =====
// Front end: configuration registers, position counters and classification.
// Depends on mpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpa_front
	import mpa_pkg::*;
#(
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
	parameter int MAX_ROWS     = DEF_MAX_ROWS,
	parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
	parameter int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
	parameter int RW_W         = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [SAMPLE_BITS-1:0] in_sample,
	output logic                        push_valid,
	input  wire logic                   push_ready,
	output pool_ctl_t                   push_ctl,
	output logic [SAMPLE_BITS-1:0]      push_sample,
	output logic [CH_W-1:0]             push_ch,
	output logic [RW_W-1:0]             push_win,
	output logic [INDEX_W-1:0]          push_flat
);

	localparam int CH_CMP_W  = (CH_W + 1 > CH_REG_W) ? CH_W + 1 : CH_REG_W;
	localparam int ROW_CMP_W = (RW_W + 1 > ROW_REG_W) ? RW_W + 1 : ROW_REG_W;

	logic [CH_REG_W-1:0]   ch_reg_q;
	logic [KERN_REG_W-1:0] kern_reg_q;
	logic [ROW_REG_W-1:0]  row_reg_q;

	logic [CH_W-1:0]    ch_pos_q;
	logic [RW_W-1:0]    row_pos_q;
	logic [RIW_W-1:0]   riw_q;
	logic [RW_W-1:0]    win_pos_q;
	logic [INDEX_W-1:0] flat_pos_q;

	logic [CH_CMP_W-1:0]   ch_lim;
	logic [ROW_CMP_W-1:0]  row_lim;
	logic [KERN_REG_W-1:0] kern_lim;
	logic last_chan, last_row, last_in_win, accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_reg_q   <= CH_RESET;
			kern_reg_q <= KERN_RESET;
			row_reg_q  <= ROW_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_addr))
				CFG_CHANNEL_COUNT: ch_reg_q   <= cfg_wdata[CH_REG_W-1:0];
				CFG_KERNEL_SIZE:   kern_reg_q <= cfg_wdata[KERN_REG_W-1:0];
				CFG_ROW_COUNT:     row_reg_q  <= cfg_wdata[ROW_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// saturate the limits into their meaningful ranges
	always_comb begin
		if (ch_reg_q == '0)
			ch_lim = CH_CMP_W'(1);
		else if (CH_CMP_W'(ch_reg_q) > CH_CMP_W'(MAX_CHANNELS))
			ch_lim = CH_CMP_W'(MAX_CHANNELS);
		else
			ch_lim = CH_CMP_W'(ch_reg_q);

		if (row_reg_q == '0)
			row_lim = ROW_CMP_W'(1);
		else if (ROW_CMP_W'(row_reg_q) > ROW_CMP_W'(MAX_ROWS))
			row_lim = ROW_CMP_W'(MAX_ROWS);
		else
			row_lim = ROW_CMP_W'(row_reg_q);

		if (kern_reg_q == '0)
			kern_lim = KERN_REG_W'(1);
		else if (kern_reg_q > KERN_REG_W'(KERNEL_MAX))
			kern_lim = KERN_REG_W'(KERNEL_MAX);
		else
			kern_lim = kern_reg_q;
	end

	assign last_chan   = (CH_CMP_W'(ch_pos_q) + CH_CMP_W'(1)) >= ch_lim;
	assign last_row    = (ROW_CMP_W'(row_pos_q) + ROW_CMP_W'(1)) >= row_lim;
	assign last_in_win = (KERN_REG_W'(riw_q) + KERN_REG_W'(1)) >= kern_lim;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign accept     = in_valid && push_ready;

	assign push_sample         = in_sample;
	assign push_ch             = ch_pos_q;
	assign push_win            = win_pos_q;
	assign push_flat           = flat_pos_q;
	assign push_ctl.first      = (riw_q == '0);
	assign push_ctl.window_end = last_in_win || last_row;
	assign push_ctl.frame_last = last_row && last_chan;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_pos_q   <= '0;
			row_pos_q  <= '0;
			riw_q      <= '0;
			win_pos_q  <= '0;
			flat_pos_q <= '0;
		end else if (accept) begin
			if (!last_chan) begin
				ch_pos_q   <= ch_pos_q + CH_W'(1);
				flat_pos_q <= flat_pos_q + INDEX_W'(1);
			end else if (last_row) begin
				// end of frame: restart every counter
				ch_pos_q   <= '0;
				row_pos_q  <= '0;
				riw_q      <= '0;
				win_pos_q  <= '0;
				flat_pos_q <= '0;
			end else begin
				ch_pos_q   <= '0;
				row_pos_q  <= row_pos_q + RW_W'(1);
				flat_pos_q <= flat_pos_q + INDEX_W'(1);
				if (last_in_win) begin
					riw_q     <= '0;
					win_pos_q <= win_pos_q + RW_W'(1);
				end else begin
					riw_q <= riw_q + RIW_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mpa_queue.sv =====
// Short first-in first-out queue that decouples front and back.
// Depends on mpa_pkg for its depth.
`timescale 1ns / 1ps
`default_nettype none

module mpa_queue
	import mpa_pkg::*;
#(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic [WIDTH-1:0]      pop_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic push, pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mpa_back.sv =====
// Back end: per-channel running maximum memory, compare stage and output register.
// Depends on mpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpa_back
	import mpa_pkg::*;
#(
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
	parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
	parameter int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
	parameter int RW_W         = 10
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   pop_valid,
	output logic                        pop_ready,
	input  wire pool_ctl_t              pop_ctl,
	input  wire logic [SAMPLE_BITS-1:0] pop_sample,
	input  wire logic [CH_W-1:0]        pop_ch,
	input  wire logic [RW_W-1:0]        pop_win,
	input  wire logic [INDEX_W-1:0]     pop_flat,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [SAMPLE_BITS-1:0]      out_value,
	output logic [INDEX_W-1:0]          out_index,
	output logic [CH_W-1:0]             out_ch,
	output logic [RW_W-1:0]             out_win,
	output logic                        out_last
);

	localparam int ENT_W = SAMPLE_BITS + INDEX_W;

	logic [ENT_W-1:0] best_mem [MAX_CHANNELS];
	logic [ENT_W-1:0] mem_rd_q;

	logic                   valid_s1;
	pool_ctl_t              ctl_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [CH_W-1:0]        ch_s1;
	logic [RW_W-1:0]        win_s1;
	logic [INDEX_W-1:0]     flat_s1;
	logic                   byp_s1;
	logic [SAMPLE_BITS-1:0] byp_val_s1;
	logic [INDEX_W-1:0]     byp_idx_s1;

	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] out_value_q;
	logic [INDEX_W-1:0]     out_index_q;
	logic [CH_W-1:0]        out_ch_q;
	logic [RW_W-1:0]        out_win_q;
	logic                   out_last_q;

	logic                   adv, pop, wr_en, take, hit;
	logic [SAMPLE_BITS-1:0] cur_val, new_val;
	logic [INDEX_W-1:0]     cur_idx, new_idx;

	// the whole back end moves when the output register is free or draining
	assign adv       = !out_valid_q || out_ready;
	assign pop_ready = adv;
	assign pop       = pop_valid && adv;
	assign wr_en     = valid_s1 && adv;

	// stored maximum, or the one written as this word was read
	assign cur_val = byp_s1 ? byp_val_s1 : mem_rd_q[ENT_W-1:INDEX_W];
	assign cur_idx = byp_s1 ? byp_idx_s1 : mem_rd_q[INDEX_W-1:0];
	// later sample wins a tie
	assign take    = ctl_s1.first || ($signed(sample_s1) >= $signed(cur_val));
	assign new_val = take ? sample_s1 : cur_val;
	assign new_idx = take ? flat_s1 : cur_idx;
	assign hit     = wr_en && (ch_s1 == pop_ch);

	always_ff @(posedge clk) begin
		if (wr_en)
			best_mem[ch_s1] <= {new_val, new_idx};
		if (pop)
			mem_rd_q <= best_mem[pop_ch];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ctl_s1     <= pop_ctl;
			sample_s1  <= pop_sample;
			ch_s1      <= pop_ch;
			win_s1     <= pop_win;
			flat_s1    <= pop_flat;
			byp_s1     <= hit;
			byp_val_s1 <= new_val;
			byp_idx_s1 <= new_idx;
		end
		if (adv) begin
			out_value_q <= new_val;
			out_index_q <= new_idx;
			out_ch_q    <= ch_s1;
			out_win_q   <= win_s1;
			out_last_q  <= ctl_s1.frame_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= pop_valid;
			out_valid_q <= valid_s1 && ctl_s1.window_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_index = out_index_q;
	assign out_ch    = out_ch_q;
	assign out_win   = out_win_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

// ===== verif/max_pool_1d_argmax_top_test.sv =====
// Self-checking bench for max_pool_1d_argmax_top: stream words in, pooled maxima out.
// Uses the shared package mpa_pkg for register indexes and widths, and the rtl top under test.
`timescale 1ns / 1ps

module max_pool_1d_argmax_top_test;
	import mpa_pkg::*;

	localparam int SMP_W        = DEF_SAMPLE_BITS;
	localparam int OUT_W        = 48;
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES  = 150;    // long receiver hold-off, fills the block
	localparam int STALL_LIMIT  = 2000;   // cycles without any transfer before giving up
	localparam int RANDOM_WORDS = 500;
	localparam int QUIET_TAIL   = 100;    // last random words run without idling
	localparam int WIDE_WORDS   = DEF_MAX_CHANNELS * 2;

	// index 3 is not decoded by the block; a write there must change nothing
	localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;

	// one pooled result, fields in m_axis order from the lowest bit up, then tlast
	typedef struct packed {
		logic [SMP_W-1:0]   value;
		logic [INDEX_W-1:0] index;
		logic [5:0]         chan;
		logic [9:0]         win;
		logic               last;
	} pool_result_t;

	typedef enum logic {STEP_WRITE, STEP_WORD} step_kind_t;

	// one row of the directed plan: a register write or an input word
	typedef struct packed {
		step_kind_t              kind;
		logic [CFG_ADDR_W-1:0]   addr;
		logic [CFG_DATA_W-1:0]   wdata;
		logic [SMP_W-1:0]        sample;
		logic                    typed;      // expectation written into the row
		logic                    typed_hit;
		pool_result_t            typed_res;
	} step_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_we        = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [SMP_W-1:0]      s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_W-1:0]      m_axis_tdata;
	logic                  m_axis_tlast;

	max_pool_1d_argmax_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),   // sample
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),   // max_value, max_index, channel_id, window_id
		.m_axis_tlast (m_axis_tlast)    // frame_last
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Register copies as last written, masked to the register widths.
	logic [CH_REG_W-1:0]   geo_channels = CH_RESET;
	logic [KERN_REG_W-1:0] geo_kernel   = KERN_RESET;
	logic [ROW_REG_W-1:0]  geo_rows     = ROW_RESET;

	// Running maxima and frame counters of the pooling predictor.
	logic [SMP_W-1:0]   run_max [DEF_MAX_CHANNELS];
	logic [INDEX_W-1:0] run_arg [DEF_MAX_CHANNELS];
	logic [5:0]         ch_pos     = '0;
	logic [9:0]         row_pos    = '0;
	logic [RIW_W-1:0]   row_in_win = '0;
	logic [9:0]         win_pos    = '0;
	logic [INDEX_W-1:0] flat_pos   = '0;

	pool_result_t due_pools[$];   // pooled results still to arrive, oldest first
	int           fails        = 0;
	bit           src_idle_on  = 1'b1;
	bit           sink_idle_on = 1'b1;
	int           hold_reqs    = 0;
	int           holds_taken  = 0;
	int           sink_left    = 0;

	initial begin
		foreach (run_max[i]) begin
			run_max[i] = '0;
			run_arg[i] = '0;
		end
	end

	// Registers outside their range act as the nearest end of it.
	function automatic int clamp_reg(int v, int hi);
		if (v < 1)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Advance the predictor by one accepted word; hit says whether a window closed.
	task automatic pool_step(input logic [SMP_W-1:0] smp, output bit hit,
			output pool_result_t res);
		int         chans;
		int         kern;
		int         rows;
		logic [5:0] c;
		bit         last_chan;
		bit         last_row;
		bit         last_win;
		chans = clamp_reg(int'(geo_channels), DEF_MAX_CHANNELS);
		kern  = clamp_reg(int'(geo_kernel), KERNEL_MAX);
		rows  = clamp_reg(int'(geo_rows), DEF_MAX_ROWS);
		c = ch_pos;
		// a counter at or past a lowered limit counts as at its last position
		last_chan = int'(ch_pos) + 1 >= chans;
		last_row  = int'(row_pos) + 1 >= rows;
		last_win  = int'(row_in_win) + 1 >= kern;
		// first row of a window restarts the maximum; ties go to the later word
		if (row_in_win == '0 || $signed(smp) >= $signed(run_max[c])) begin
			run_max[c] = smp;
			run_arg[c] = flat_pos;
		end
		hit = last_win || last_row;
		res = {run_max[c], run_arg[c], c, win_pos, last_row && last_chan};
		if (!last_chan) begin
			ch_pos   = ch_pos + 6'd1;
			flat_pos = flat_pos + INDEX_W'(1);
		end else if (last_row) begin
			ch_pos     = '0;
			row_pos    = '0;
			row_in_win = '0;
			win_pos    = '0;
			flat_pos   = '0;
		end else begin
			ch_pos  = '0;
			row_pos = row_pos + 10'd1;
			if (last_win) begin
				row_in_win = '0;
				win_pos    = win_pos + 10'd1;
			end else begin
				row_in_win = row_in_win + RIW_W'(1);
			end
			flat_pos = flat_pos + INDEX_W'(1);
		end
	endtask

	// Offer one word, wait for its handshake, then log what it should produce.
	task automatic offer_word(input logic [SMP_W-1:0] smp, input bit typed,
			input bit typed_hit, input pool_result_t typed_res);
		bit           hit;
		pool_result_t res;
		if (src_idle_on && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= smp;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pool_step(smp, hit, res);
		if (typed) begin
			hit = typed_hit;
			res = typed_res;
		end
		if (hit)
			due_pools.push_back(res);
	endtask

	// Hold the source until every pooled result is out and the pipe has emptied.
	task automatic settle_block();
		s_axis_tvalid <= 1'b0;
		while (due_pools.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_DATA_W-1:0] v);
		settle_block();
		cfg_we    <= 1'b1;
		cfg_addr  <= a;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (a)
			CFG_CHANNEL_COUNT: geo_channels = v[CH_REG_W-1:0];
			CFG_KERNEL_SIZE:   geo_kernel   = v[KERN_REG_W-1:0];
			CFG_ROW_COUNT:     geo_rows     = v;
			default: ;
		endcase
	endtask

	// Mix full-range values with the extremes and a narrow band that forces ties.
	function automatic logic [SMP_W-1:0] draw_sample();
		int r;
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 3))
					0: r = 32'h8000;
					1: r = 32'h7FFF;
					2: r = 0;
					default: r = 32'hFFFF;
				endcase
			end
			1, 2: r = int'($urandom_range(0, 4)) - 2;
			default: r = $urandom();
		endcase
		return r[SMP_W-1:0];
	endfunction

	function automatic step_t write_row(logic [CFG_ADDR_W-1:0] a, int v);
		step_t r;
		r       = '0;
		r.kind  = STEP_WRITE;
		r.addr  = a;
		r.wdata = v[CFG_DATA_W-1:0];
		return r;
	endfunction

	// word checked against the predictor only
	function automatic step_t word_row(int s);
		step_t r;
		r        = '0;
		r.kind   = STEP_WORD;
		r.sample = s[SMP_W-1:0];
		return r;
	endfunction

	// word with its outcome written out by hand
	function automatic step_t known_row(int s, bit hit, int v, int i, int ch, int w, bit last);
		step_t r;
		r           = word_row(s);
		r.typed     = 1'b1;
		r.typed_hit = hit;
		r.typed_res = {v[SMP_W-1:0], i[INDEX_W-1:0], ch[5:0], w[9:0], last};
		return r;
	endfunction

	// Result side: check every word against the oldest expectation, then pick
	// the next ready level. A hold-off request overrides the random stalls.
	always @(posedge clk) begin : result_sink
		pool_result_t want;
		pool_result_t seen;
		if (m_axis_tvalid && m_axis_tready) begin
			seen = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[37:32],
				m_axis_tdata[47:38], m_axis_tlast};
			if (due_pools.size() == 0) begin
				$error("result with none due: max_value %0d max_index %0d channel_id %0d",
					$signed(seen.value), seen.index, seen.chan);
				fails++;
			end else begin
				want = due_pools.pop_front();
				if (seen.value !== want.value) begin
					$error("max_value: expected %0d, got %0d",
						$signed(want.value), $signed(seen.value));
					fails++;
				end
				if (seen.index !== want.index) begin
					$error("max_index: expected %0d, got %0d", want.index, seen.index);
					fails++;
				end
				if (seen.chan !== want.chan) begin
					$error("channel_id: expected %0d, got %0d", want.chan, seen.chan);
					fails++;
				end
				if (seen.win !== want.win) begin
					$error("window_id: expected %0d, got %0d", want.win, seen.win);
					fails++;
				end
				if (seen.last !== want.last) begin
					$error("frame_last: expected %0d, got %0d", want.last, seen.last);
					fails++;
				end
			end
		end
		if (holds_taken != hold_reqs) begin
			holds_taken = hold_reqs;
			sink_left   = HOLD_CYCLES;
		end else if (sink_left == 0 && sink_idle_on && $urandom_range(0, 3) == 0) begin
			sink_left = $urandom_range(1, 4);
		end
		if (sink_left > 0) begin
			m_axis_tready <= 1'b0;
			sink_left--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Give up once nothing has moved on any port for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		step_t        plan[$];
		pool_result_t no_res;
		int           rand_words;
		int           n;
		int           ch_v;
		int           kern_v;
		int           rows_v;
		int           eff_ch;
		bit           close_frame;
		no_res = '0;

		// Registers at reset: one channel, windows of two rows, two rows a frame.
		plan.push_back(known_row(-32768, 1'b0, 0, 0, 0, 0, 1'b0));
		plan.push_back(known_row(32767, 1'b1, 32767, 1, 0, 0, 1'b1));
		plan.push_back(known_row(5, 1'b0, 0, 0, 0, 0, 1'b0));
		plan.push_back(known_row(5, 1'b1, 5, 1, 0, 0, 1'b1));       // tie: later index
		plan.push_back(known_row(-1, 1'b0, 0, 0, 0, 0, 1'b0));
		plan.push_back(known_row(-32768, 1'b1, -1, 0, 0, 0, 1'b1));
		// an undecoded index changes nothing
		plan.push_back(write_row(CFG_UNUSED, 2047));
		// zero kernel and row count act as one: every word closes its own window
		plan.push_back(write_row(CFG_KERNEL_SIZE, 0));
		plan.push_back(write_row(CFG_CHANNEL_COUNT, 3));
		plan.push_back(write_row(CFG_ROW_COUNT, 0));
		plan.push_back(known_row(100, 1'b1, 100, 0, 0, 0, 1'b0));
		plan.push_back(known_row(-100, 1'b1, -100, 1, 1, 0, 1'b0));
		plan.push_back(known_row(0, 1'b1, 0, 2, 2, 0, 1'b1));
		// zero channels act as one, oversize kernel as 64: the frame end closes it
		plan.push_back(write_row(CFG_CHANNEL_COUNT, 0));
		plan.push_back(write_row(CFG_KERNEL_SIZE, 127));
		plan.push_back(write_row(CFG_ROW_COUNT, 3));
		plan.push_back(known_row(7, 1'b0, 0, 0, 0, 0, 1'b0));
		plan.push_back(known_row(9, 1'b0, 0, 0, 0, 0, 1'b0));
		plan.push_back(known_row(9, 1'b1, 9, 2, 0, 0, 1'b1));
		// two channels, short final window of one row
		plan.push_back(write_row(CFG_CHANNEL_COUNT, 2));
		plan.push_back(write_row(CFG_KERNEL_SIZE, 2));
		plan.push_back(word_row(10));
		plan.push_back(word_row(-20));
		plan.push_back(word_row(10));
		plan.push_back(word_row(30));
		plan.push_back(word_row(-32768));
		plan.push_back(word_row(32767));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == STEP_WRITE)
				write_reg(plan[i].addr, plan[i].wdata);
			else
				offer_word(plan[i].sample, plan[i].typed, plan[i].typed_hit, plan[i].typed_res);
		end

		// Every word a result; hold the receiver off so the block backs up and
		// stalls its input while the source keeps offering.
		write_reg(CFG_CHANNEL_COUNT, 2);
		write_reg(CFG_KERNEL_SIZE, 1);
		write_reg(CFG_ROW_COUNT, 8);
		hold_reqs <= hold_reqs + 1;
		repeat (48) offer_word(draw_sample(), 1'b0, 1'b0, no_res);

		// Widest rows, one result per word: channel_id reaches its maximum.
		// Oversize rows act as 1024, so the two rows sent do not close the frame.
		write_reg(CFG_CHANNEL_COUNT, DEF_MAX_CHANNELS);
		write_reg(CFG_KERNEL_SIZE, 0);
		write_reg(CFG_ROW_COUNT, 2047);
		repeat (WIDE_WORDS) offer_word(draw_sample(), 1'b0, 1'b0, no_res);

		// Random geometry. Rewrite registers only at the first row of a window,
		// sometimes mid-frame, so no running maximum is read before it is set.
		rand_words = 0;
		while (rand_words < RANDOM_WORDS) begin
			if (rand_words >= RANDOM_WORDS - QUIET_TAIL) begin
				src_idle_on = 1'b0;
				sink_idle_on <= 1'b0;
			end
			case ($urandom_range(0, 7))
				0: ch_v = 0;
				1: ch_v = DEF_MAX_CHANNELS;
				2: ch_v = $urandom_range(65, 2047);
				default: ch_v = $urandom_range(1, 8);
			endcase
			eff_ch = clamp_reg(ch_v & 127, DEF_MAX_CHANNELS);
			if (eff_ch > 8) begin
				kern_v = $urandom_range(0, 3);
				rows_v = $urandom_range(0, 4);
			end else begin
				case ($urandom_range(0, 5))
					0: kern_v = KERNEL_MAX;
					1: kern_v = 127;
					2: kern_v = $urandom_range(128, 2047);
					default: kern_v = $urandom_range(0, 6);
				endcase
				rows_v = $urandom_range(0, 10);
			end
			write_reg(CFG_CHANNEL_COUNT, ch_v[CFG_DATA_W-1:0]);
			write_reg(CFG_KERNEL_SIZE, kern_v[CFG_DATA_W-1:0]);
			write_reg(CFG_ROW_COUNT, rows_v[CFG_DATA_W-1:0]);
			n = $urandom_range(5, 40);
			close_frame = ($urandom_range(0, 2) == 0);
			repeat (n) begin
				offer_word(draw_sample(), 1'b0, 1'b0, no_res);
				rand_words++;
			end
			// advance to a window start, or to the frame end now and then
			while (row_in_win != '0 || (close_frame && (row_pos != '0 || ch_pos != '0))) begin
				offer_word(draw_sample(), 1'b0, 1'b0, no_res);
				rand_words++;
			end
		end

		settle_block();
		if (fails == 0 && due_pools.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== max_pool_1d_argmax_top.f =====
rtl/mpa_pkg.sv
rtl/mpa_front.sv
rtl/mpa_queue.sv
rtl/mpa_back.sv
rtl/max_pool_1d_argmax_top.sv
verif/max_pool_1d_argmax_top_test.sv
